// ===== hw/rtl/lkvc_pkg.sv =====
// Shared types and codes for the pinned LRU key/value cache.
package lkvc_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [4:0] LIMIT_RESET = 5'd16;
  localparam logic [7:0] DEPTH_MAX   = 8'd255;

  localparam logic [2:0] MODE_PUT    = 3'd0;
  localparam logic [2:0] MODE_FIND   = 3'd1;
  localparam logic [2:0] MODE_LOCK   = 3'd2;
  localparam logic [2:0] MODE_UNLOCK = 3'd3;
  localparam logic [2:0] MODE_DIS    = 3'd4;
  localparam logic [2:0] MODE_EN     = 3'd5;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_ABSENT        = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW     = 3'd2;
  localparam logic [2:0] ST_ALL_LOCKED    = 3'd3;
  localparam logic [2:0] ST_FULL_DISABLED = 3'd4;
  localparam logic [2:0] ST_SATURATED     = 3'd5;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] lookup_key;
    logic [31:0] put_value;
  } in_word_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic [2:0]  status;
    logic [4:0]  occupancy;
    logic [4:0]  evicted_count;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_DISP,
    S_CULL,
    S_MIN,
    S_EVICT,
    S_DEC,
    S_FREE,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/lkvc_store.sv =====
// Entry memory: key, value and age rank, one write and one registered read port.
module lkvc_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 68
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lru_key_value_cache_with_pinning.sv =====
// Top level of the pinned LRU key/value cache: sequencer around the entry memory.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+---------------------------------------
//  in_     | input     | in_valid/in_ready  | mode, lookup_key, put_value
//  out_    | output    | out_valid/out_ready| hit, read_value, status, occupancy, evicted
//  cfg_    | input     | cfg_we             | occupancy_limit (5 bits)
//
// One word at a time. Every op starts with a key scan through the single read
// port of the entry memory. A put hit adds a rank-close sweep and a free-slot
// scan. Each eviction costs a min-rank sweep plus a rank-close sweep.
// Reset is synchronous; valid and pin bits are flops, so there is no clearing pass.
// A finished result waits in the output register; the next op may run meanwhile
// but its own result holds until the output register is free.
module lru_key_value_cache_with_pinning #(
  parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lkvc_pkg::in_word_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lkvc_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata
);

  import lkvc_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = IW + 1;
  localparam int RW = IW;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int EW = KEY_BITS + VALUE_BITS + RW;

  // control state
  state_t              state_r, state_nxt;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [ENTRIES-1:0]  pinned_r, pinned_nxt;
  logic [OW-1:0]       occ_r, occ_nxt;
  logic [7:0]          depth_r, depth_nxt;
  logic [4:0]          lim_r;
  logic                out_valid_r, out_valid_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                pend_r, pend_nxt;
  logic                culling_r, culling_nxt;
  logic                ins_r, ins_nxt;

  // working payload
  in_word_t            word_r, word_nxt;
  logic [IW-1:0]       pidx_r, pidx_nxt;
  logic                found_r, found_nxt;
  logic [IW-1:0]       slot_r, slot_nxt;
  logic [RW-1:0]       rank_r, rank_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [RW-1:0]       rem_rank_r, rem_rank_nxt;
  logic [OW-1:0]       evict_r, evict_nxt;
  logic [2:0]          status_r, status_nxt;
  logic                hit_r, hit_nxt;
  out_word_t           out_r, out_nxt;

  // memory port
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [EW-1:0]       mem_wdata;
  logic [IW-1:0]       mem_raddr;
  logic [EW-1:0]       mem_rdata;

  logic [KEY_BITS-1:0]   rkey;
  logic [VALUE_BITS-1:0] rval;
  logic [RW-1:0]         rrank;
  logic [KEY_BITS-1:0]   key_w;
  logic [OW-1:0]         eff_lim;
  logic                  issue;
  logic                  last;

  lkvc_store #(
    .DEPTH(ENTRIES),
    .WIDTH(EW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign rkey  = mem_rdata[EW-1 -: KEY_BITS];
  assign rval  = mem_rdata[RW +: VALUE_BITS];
  assign rrank = mem_rdata[RW-1:0];
  assign key_w = KEY_BITS'(word_r.lookup_key);

  // limit of 0 acts as 1, above ENTRIES acts as ENTRIES
  always_comb begin
    if (lim_r == 5'd0) begin
      eff_lim = OW'(1);
    end else if (int'(lim_r) > ENTRIES) begin
      eff_lim = OW'(ENTRIES);
    end else begin
      eff_lim = OW'(lim_r);
    end
  end

  // sweep bookkeeping shared by the scan states
  assign issue = (idx_r < CW'(ENTRIES));
  assign last  = pend_r && (pidx_r == IW'(ENTRIES - 1));

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    pinned_nxt    = pinned_r;
    occ_nxt       = occ_r;
    depth_nxt     = depth_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    culling_nxt   = culling_r;
    ins_nxt       = ins_r;
    word_nxt      = word_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    rank_nxt      = rank_r;
    val_nxt       = val_r;
    rem_rank_nxt  = rem_rank_r;
    evict_nxt     = evict_r;
    status_nxt    = status_r;
    hit_nxt       = hit_r;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = slot_r;
    mem_wdata     = {key_w, VALUE_BITS'(word_r.put_value), RW'(occ_r)};
    mem_raddr     = idx_r[IW-1:0];

    // issue side of a sweep: one read a cycle, data back in the cycle after the read
    if ((state_r == S_LOOK || state_r == S_MIN || state_r == S_DEC) && issue) begin
      idx_nxt  = idx_r + CW'(1);
      pend_nxt = 1'b1;
      pidx_nxt = idx_r[IW-1:0];
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          word_nxt   = in_data;
          found_nxt  = 1'b0;
          hit_nxt    = 1'b0;
          val_nxt    = '0;
          status_nxt = ST_OK;
          evict_nxt  = '0;
          idx_nxt    = '0;
          state_nxt  = S_LOOK;
        end
      end
      S_LOOK: begin
        if (pend_r && valid_r[pidx_r] && rkey == key_w && !found_r) begin
          found_nxt = 1'b1;
          slot_nxt  = pidx_r;
          rank_nxt  = rrank;
          val_nxt   = rval;
        end
        if (last) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_DONE;
        case (word_r.mode)
          MODE_PUT: begin
            if (found_r) begin
              hit_nxt            = 1'b1;
              valid_nxt[slot_r]  = 1'b0;
              pinned_nxt[slot_r] = 1'b0;
              occ_nxt            = occ_r - OW'(1);
              rem_rank_nxt       = rank_r;
              culling_nxt        = 1'b0;
              idx_nxt            = '0;
              state_nxt          = S_DEC;
            end else if (depth_r == 8'd0) begin
              culling_nxt = 1'b1;
              ins_nxt     = 1'b1;
              state_nxt   = S_CULL;
            end else if (occ_r >= OW'(ENTRIES)) begin
              status_nxt = ST_FULL_DISABLED;
            end else begin
              idx_nxt   = '0;
              state_nxt = S_FREE;
            end
          end
          MODE_FIND: begin
            if (found_r) begin
              hit_nxt = 1'b1;
            end else begin
              status_nxt = ST_ABSENT;
            end
          end
          MODE_LOCK, MODE_UNLOCK: begin
            if (found_r) begin
              hit_nxt            = 1'b1;
              pinned_nxt[slot_r] = (word_r.mode == MODE_LOCK);
            end else begin
              status_nxt = ST_ABSENT;
            end
          end
          MODE_DIS: begin
            if (depth_r == DEPTH_MAX) begin
              status_nxt = ST_SATURATED;
            end else begin
              depth_nxt = depth_r + 8'd1;
            end
          end
          MODE_EN: begin
            if (depth_r == 8'd0) begin
              status_nxt = ST_UNDERFLOW;
            end else begin
              depth_nxt = depth_r - 8'd1;
              if (depth_r == 8'd1) begin
                culling_nxt = 1'b1;
                ins_nxt     = 1'b0;
                state_nxt   = S_CULL;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_CULL: begin
        if (occ_r >= eff_lim) begin
          found_nxt = 1'b0;
          idx_nxt   = '0;
          state_nxt = S_MIN;
        end else if (ins_r) begin
          idx_nxt   = '0;
          state_nxt = S_FREE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MIN: begin
        // oldest unpinned valid entry
        if (pend_r && valid_r[pidx_r] && !pinned_r[pidx_r] &&
            (!found_r || rrank < rank_r)) begin
          found_nxt = 1'b1;
          slot_nxt  = pidx_r;
          rank_nxt  = rrank;
        end
        if (last) begin
          state_nxt = S_EVICT;
        end
      end
      S_EVICT: begin
        if (!found_r) begin
          status_nxt = ST_ALL_LOCKED;
          state_nxt  = S_DONE;
        end else begin
          valid_nxt[slot_r]  = 1'b0;
          pinned_nxt[slot_r] = 1'b0;
          occ_nxt            = occ_r - OW'(1);
          evict_nxt          = evict_r + OW'(1);
          rem_rank_nxt       = rank_r;
          idx_nxt            = '0;
          state_nxt          = S_DEC;
        end
      end
      S_DEC: begin
        // close the rank gap left by the removed entry
        if (pend_r && valid_r[pidx_r] && rrank > rem_rank_r) begin
          mem_we    = 1'b1;
          mem_waddr = pidx_r;
          mem_wdata = {rkey, rval, rrank - RW'(1)};
        end
        if (last) begin
          idx_nxt   = '0;
          state_nxt = culling_r ? S_CULL : S_FREE;
        end
      end
      S_FREE: begin
        if (!issue) begin
          state_nxt = S_DONE;
        end else if (!valid_r[idx_r[IW-1:0]]) begin
          slot_nxt  = idx_r[IW-1:0];
          state_nxt = S_WRITE;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_WRITE: begin
        mem_we             = 1'b1;
        valid_nxt[slot_r]  = 1'b1;
        pinned_nxt[slot_r] = 1'b0;
        occ_nxt            = occ_r + OW'(1);
        state_nxt          = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.hit           = hit_r;
          out_nxt.read_value    = (word_r.mode == MODE_FIND && hit_r) ?
                                  32'(val_r) : 32'd0;
          out_nxt.status        = status_r;
          out_nxt.occupancy     = 5'(occ_r);
          out_nxt.evicted_count = 5'(evict_r);
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      pinned_r    <= '0;
      occ_r       <= '0;
      depth_r     <= '0;
      lim_r       <= LIMIT_RESET;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      culling_r   <= 1'b0;
      ins_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      pinned_r    <= pinned_nxt;
      occ_r       <= occ_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      culling_r   <= culling_nxt;
      ins_r       <= ins_nxt;
      if (cfg_we) begin
        lim_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    pidx_r     <= pidx_nxt;
    found_r    <= found_nxt;
    slot_r     <= slot_nxt;
    rank_r     <= rank_nxt;
    val_r      <= val_nxt;
    rem_rank_r <= rem_rank_nxt;
    evict_r    <= evict_nxt;
    status_r   <= status_nxt;
    hit_r      <= hit_nxt;
    out_r      <= out_nxt;
  end

  // occupancy count tracks the valid bits whenever idle
  a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> $countones(valid_r) == int'(occ_r))
    else $error("occupancy count out of step with valid bits");

  // a pinned entry is always a valid entry
  a_pin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (pinned_r & ~valid_r) == '0)
    else $error("pin bit set on an invalid entry");

  // an eviction only happens with occupancy at or above the limit
  a_evict_lim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVICT && found_r) |-> occ_r >= eff_lim)
    else $error("eviction below occupancy limit");

  // occupancy never passes the store size
  a_occ_max: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(ENTRIES))
    else $error("occupancy above store size");

endmodule
